// ===== rtl/core/ebd_pkg.sv =====
// ----------------------------------------------------------------------------
// Eye blink detector package
// Shared types and constants for the blink detector and its divider.
// ----------------------------------------------------------------------------
package ebd_pkg;

	localparam int DivW = 48;

	localparam logic [2:0] RegEarThreshold = 3'd0;
	localparam logic [2:0] RegMinClosed    = 3'd1;
	localparam logic [2:0] RegMaxClosed    = 3'd2;
	localparam logic [2:0] RegUpdatePeriod = 3'd3;
	localparam logic [2:0] RegFramesPerMin = 3'd4;

	localparam logic [23:0] Max24 = 24'hFFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_P,
		ST_WAIT_P,
		ST_DIV_L,
		ST_WAIT_L,
		ST_DIV_R,
		ST_WAIT_R,
		ST_EVAL,
		ST_DIV_F,
		ST_WAIT_F,
		ST_DIV_I,
		ST_WAIT_I,
		ST_DIV_D,
		ST_WAIT_D,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quo;
		logic [DivW-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/core/ebd_divider.sv =====
// ----------------------------------------------------------------------------
// Eye blink detector divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ebd_divider
	import ebd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CntW = $clog2(DivW + 1);

	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] quo_q;
	logic [DivW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DivW:0]   trial;

	assign trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DivW]) begin
				rem_q <= trial[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/core/eye_blink_detector_stats.sv =====
// ----------------------------------------------------------------------------
// Eye blink detector with blink statistics
// Eye aspect ratios, closed-run blink detection and a blink history ring.
// ----------------------------------------------------------------------------
// One frame is one transaction in and one transaction out. A single shared
// 48-bit divider that yields one quotient bit per cycle does all the work;
// each division is started, shifts out its 48 quotient bits and then signals
// done. Every frame first divides the frame count by the update period to
// find statistics frames; frames with a face then divide out both eye ratios,
// and statistics frames divide out frequency, interval and duration. The
// block takes no new frame until the result has been taken.
module eye_blink_detector_stats
	import ebd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// left_vert_outer, left_vert_inner, left_horizontal,
	// right_vert_outer, right_vert_inner, right_horizontal
	input  logic [95:0]  s_axis_tdata,
	// face_detected
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// mean_ratio, left_ratio, right_ratio, blink_total, blinks_per_minute,
	// seconds_between, seconds_closed
	output logic [151:0] m_axis_tdata,
	// blink_found, stats_updated
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int HW = $clog2(HISTORY_DEPTH + 1);
	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	logic [15:0] ear_thr_q, fpm_q;
	logic [7:0]  min_q, max_q, period_q;

	state_t state_q, state_d;

	logic [31:0] frame_q, run_start_q, blinks_q, closed_sum_q;
	logic [7:0]  closed_run_q;
	logic        run_open_q;
	logic        on_period_q;
	logic [IW-1:0] head_q;
	logic [HW-1:0] count_q;
	logic [31:0] hist_start_q [HISTORY_DEPTH];
	logic [31:0] hist_end_q   [HISTORY_DEPTH];
	logic [31:0] hist_gap_q   [HISTORY_DEPTH];
	logic [23:0] freq_q, intv_q, dur_q;

	logic [95:0] in_q;
	logic        face_q;
	logic [15:0] left_q, right_q, mean_q;
	logic        found_q, upd_q;
	logic [31:0] span_q;
	logic [39:0] pc_q;

	div_req_t dreq;
	div_rsp_t drsp;

	ebd_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [7:0] period;
	assign period = (period_q == 8'd0) ? 8'd1 : period_q;

	function automatic logic [15:0] sat16(input logic [DivW-1:0] q);
		return (q > DivW'(16'hFFFF)) ? 16'hFFFF : q[15:0];
	endfunction
	function automatic logic [23:0] sat24(input logic [DivW-1:0] q);
		return (q > DivW'(Max24)) ? Max24 : q[23:0];
	endfunction
	function automatic logic [IW-1:0] wrap(input logic [HW:0] v);
		return (v >= (HW+1)'(HISTORY_DEPTH)) ? IW'(v - (HW+1)'(HISTORY_DEPTH)) : IW'(v);
	endfunction

	// Slot indexes into the ring.
	logic [IW-1:0] newest, tail;
	assign newest = wrap({1'b0, HW'(head_q)} + {1'b0, count_q} - (HW+1)'(1));
	assign tail   = wrap({1'b0, HW'(head_q)} + {1'b0, count_q});

	// Evaluation of the closed run, done in ST_EVAL.
	logic        closed, blink;
	logic [31:0] gap, open_t;
	logic        stat_frame;
	logic [HW-1:0] count_n;
	logic [IW-1:0] head_n, slot;
	logic [31:0] csum_n;
	always_comb begin
		closed  = face_q && (mean_q <= ear_thr_q);
		blink   = face_q && !closed && run_open_q && closed_run_q >= min_q &&
			closed_run_q < max_q;
		gap     = (count_q != '0) ? run_start_q - hist_end_q[newest] - 32'd1 : run_start_q;
		csum_n  = closed_sum_q;
		count_n = count_q;
		head_n  = head_q;
		slot    = tail;
		open_t  = '0;
		if (blink) begin
			csum_n = closed_sum_q + (frame_q - run_start_q + 32'd1);
			if (count_q >= HW'(HISTORY_DEPTH)) begin
				csum_n = csum_n - (hist_end_q[head_q] - hist_start_q[head_q] + 32'd1);
				slot   = head_q;
				head_n = wrap({1'b0, HW'(head_q)} + (HW+1)'(1));
			end else begin
				count_n = count_q + 1'b1;
			end
		end
		stat_frame = (count_n != '0) && on_period_q;
		open_t = (span_q >= closed_sum_q) ? span_q - closed_sum_q : 32'd0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_DIV_P;
			ST_DIV_P:  state_d = ST_WAIT_P;
			ST_WAIT_P: if (drsp.done) state_d = face_q ? ST_DIV_L : ST_EVAL;
			ST_DIV_L:  state_d = ST_WAIT_L;
			ST_WAIT_L: if (drsp.done) state_d = ST_DIV_R;
			ST_DIV_R:  state_d = ST_WAIT_R;
			ST_WAIT_R: if (drsp.done) state_d = ST_EVAL;
			ST_EVAL:   state_d = stat_frame ? ST_DIV_F : ST_OUT;
			ST_DIV_F:  state_d = ST_WAIT_F;
			ST_WAIT_F: if (drsp.done) state_d = ST_DIV_I;
			ST_DIV_I:  state_d = ST_WAIT_I;
			ST_WAIT_I: if (drsp.done) state_d = ST_DIV_D;
			ST_DIV_D:  state_d = ST_WAIT_D;
			ST_WAIT_D: if (drsp.done) state_d = ST_OUT;
			ST_OUT:    if (m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		case (state_q)
			ST_DIV_P: begin
				// The remainder tells whether this frame falls on the update period.
				dreq.start = 1'b1;
				dreq.num   = DivW'(frame_q);
				dreq.den   = DivW'(period);
			end
			ST_DIV_L: begin
				dreq.start = 1'b1;
				dreq.num   = DivW'({17'd0, in_q[15:0]} + {17'd0, in_q[31:16]}) << 13;
				dreq.den   = DivW'(in_q[47:32]);
			end
			ST_DIV_R: begin
				dreq.start = 1'b1;
				dreq.num   = DivW'({17'd0, in_q[63:48]} + {17'd0, in_q[79:64]}) << 13;
				dreq.den   = DivW'(in_q[95:80]);
			end
			ST_DIV_F: begin
				dreq.start = 1'b1;
				dreq.num   = DivW'(DivW'(count_q) * DivW'(fpm_q)) << 8;
				dreq.den   = DivW'(span_q);
			end
			ST_DIV_I: begin
				dreq.start = 1'b1;
				dreq.num   = DivW'(open_t) << 8;
				dreq.den   = DivW'(pc_q);
			end
			ST_DIV_D: begin
				dreq.start = 1'b1;
				dreq.num   = DivW'(closed_sum_q) << 8;
				dreq.den   = DivW'(pc_q);
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {dur_q, intv_q, freq_q, blinks_q, right_q, left_q, mean_q};
	assign m_axis_tuser  = {upd_q, found_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ear_thr_q <= 16'd4588;
			min_q     <= 8'd3;
			max_q     <= 8'd8;
			period_q  <= 8'd30;
			fpm_q     <= 16'd1800;
		end else if (cfg_we) begin
			case (cfg_index)
				RegEarThreshold: ear_thr_q <= cfg_data;
				RegMinClosed:    min_q     <= cfg_data[7:0];
				RegMaxClosed:    max_q     <= cfg_data[7:0];
				RegUpdatePeriod: period_q  <= cfg_data[7:0];
				RegFramesPerMin: fpm_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_q      <= '0;
			on_period_q  <= 1'b0;
			closed_run_q <= '0;
			run_open_q   <= 1'b0;
			run_start_q  <= '0;
			blinks_q     <= '0;
			closed_sum_q <= '0;
			head_q       <= '0;
			count_q      <= '0;
			freq_q       <= '0;
			intv_q       <= '0;
			dur_q        <= '0;
			found_q      <= 1'b0;
			upd_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					frame_q <= frame_q + 32'd1;
					found_q <= 1'b0;
					upd_q   <= 1'b0;
				end
				ST_WAIT_P: if (drsp.done) on_period_q <= (drsp.rem == '0);
				ST_EVAL: begin
					if (face_q) begin
						if (closed) begin
							if (closed_run_q != 8'hFF) closed_run_q <= closed_run_q + 8'd1;
							if (!run_open_q) begin
								run_open_q  <= 1'b1;
								run_start_q <= frame_q;
							end
						end else begin
							closed_run_q <= '0;
							run_open_q   <= 1'b0;
						end
					end
					if (blink) begin
						closed_sum_q <= csum_n;
						count_q      <= count_n;
						head_q       <= head_n;
						blinks_q     <= blinks_q + 32'd1;
						found_q      <= 1'b1;
					end
					upd_q <= stat_frame;
				end
				ST_WAIT_F: if (drsp.done) freq_q <= sat24(drsp.quo);
				ST_WAIT_I: if (drsp.done) intv_q <= sat24(drsp.quo);
				ST_WAIT_D: if (drsp.done) dur_q  <= sat24(drsp.quo);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) begin
				in_q   <= s_axis_tdata;
				face_q <= s_axis_tuser;
				left_q <= '0;
				right_q <= '0;
				mean_q <= '0;
			end
			ST_WAIT_L: if (drsp.done)
				left_q <= (in_q[47:32] == 16'd0) ? 16'hFFFF : sat16(drsp.quo);
			ST_WAIT_R: if (drsp.done) begin
				right_q <= (in_q[95:80] == 16'd0) ? 16'hFFFF : sat16(drsp.quo);
				mean_q  <= 16'(({1'b0, left_q} +
					{1'b0, (in_q[95:80] == 16'd0) ? 16'hFFFF : sat16(drsp.quo)}) >> 1);
			end
			ST_EVAL: begin
				if (blink) begin
					hist_start_q[slot] <= run_start_q;
					hist_end_q[slot]   <= frame_q;
					hist_gap_q[slot]   <= gap;
				end
				// When the oldest entry is the one written now, its new values are used.
				span_q <= frame_q - ((blink && slot == head_n) ? run_start_q - gap :
					hist_start_q[head_n] - hist_gap_q[head_n]) + 32'd1;
				pc_q <= 40'(period) * 40'(count_n);
			end
			default: ;
		endcase
	end

	a_busy_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input accepted while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= HW'(HISTORY_DEPTH))
		else $error("history count overflow");
	a_found_total: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (blinks_q != 32'd0))
		else $error("blink flagged with zero total");

endmodule
